// ----- rtl/core/hdt_pkg.sv -----
// Shared types, constants and helper functions for the haptic detent torque block.
// No dependencies; the top level and the divider import this package.
`default_nettype none
package hdt_pkg;

	localparam int ANGLE_BITS    = 14;
	localparam int UNWRAP_BITS   = 32;
	localparam int FRACTION_BITS = 12;

	// Detent index and error width, divider widths, widest product.
	localparam int NB     = UNWRAP_BITS + 2;
	localparam int NUM_W  = NB + FRACTION_BITS;
	localparam int DIVN_W = NUM_W + 2;
	localparam int PW     = NB + 17;
	localparam int WIDE   = NB + 18;
	localparam int CNT_W  = $clog2(DIVN_W + 1);

	localparam logic [2:0] REG_WIDTH   = 3'd0;
	localparam logic [2:0] REG_LOWER   = 3'd1;
	localparam logic [2:0] REG_UPPER   = 3'd2;
	localparam logic [2:0] REG_SNAP    = 3'd3;
	localparam logic [2:0] REG_DGAIN   = 3'd4;
	localparam logic [2:0] REG_EGAIN   = 3'd5;
	localparam logic [2:0] REG_ANCHOR  = 3'd6;

	localparam logic signed [15:0] NO_BOUND = -16'sd1;

	typedef enum logic [3:0] {
		S_IDLE, S_UNW, S_ANC, S_DIFF, S_DIV1, S_MUL, S_ERR, S_GAIN, S_TORQ, S_DIV2, S_OUT
	} state_t;

	function automatic logic signed [15:0] sat16(input logic signed [WIDE-1:0] v);
		logic signed [15:0] r;
		if (v > WIDE'(32767)) r = 16'sh7fff;
		else if (v < -WIDE'(32768)) r = -16'sh8000;
		else r = v[15:0];
		return r;
	endfunction

	function automatic logic signed [NB-1:0] clamp_idx(input logic signed [NB-1:0] n,
			input logic signed [15:0] lo, input logic signed [15:0] hi);
		logic signed [NB-1:0] r;
		r = n;
		if (lo != NO_BOUND && r < NB'(lo)) r = NB'(lo);
		if (hi != NO_BOUND && r > NB'(hi)) r = NB'(hi);
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/core/haptic_detent_torque.sv -----
// Haptic detent torque block: unwraps an encoder angle each tick and returns spring or
// endstop torque, the detent index and the fraction of a detent.
// Depends on hdt_pkg and hdt_div.
//
// A request steps through the unwrap, the re-anchor, a first pass through the shared
// bit-serial divider, the multiply and error check, the gain multiply and torque clamp,
// a second divider pass and the output hand-off; the snap step repeats the multiply and
// error check once. Each divider pass yields 48 quotient bits, one a cycle, and then a
// registered finished flag. With a zero detent width the block goes from the difference
// step straight to the output hand-off. The input is taken only while the sequencer is
// idle. A finished result waits in an output register while the next request is taken.
// A further result that finds that register still full holds the sequencer, and so the
// input, until the waiting result is taken.
`default_nettype none
module haptic_detent_torque (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [hdt_pkg::ANGLE_BITS-1:0] encoder_angle,
	input  wire logic                           reanchor,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic signed [15:0]                  torque,
	output logic signed [15:0]                  position,
	output logic signed [15:0]                  sub_position,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [2:0]                     cfg_index,
	input  wire logic [15:0]                    cfg_data
);
	import hdt_pkg::*;

	state_t state_q, state_d;

	logic [14:0]        width_q;
	logic signed [15:0] lower_q, upper_q, anchor_pos_q;
	logic [9:0]         snap_q;
	logic [15:0]        dgain_q, egain_q;

	logic                   seeded_q;
	logic [ANGLE_BITS-1:0]  last_raw_q, raw_q;
	logic                   reanchor_q;
	logic [UNWRAP_BITS-1:0] unwrapped_q, anchor_q;
	logic signed [15:0]     held_pos_q, held_frac_q, torque_q;

	logic signed [NB-1:0]   d_q, n_q, err_q;
	logic signed [PW-1:0]   prod_q;
	logic                   neg_q, snapped_q;

	logic                   div_start, div_done;
	logic [NUM_W-1:0]       div_num;
	logic [DIVN_W-1:0]      div_quo;

	logic [ANGLE_BITS-1:0]  diff;
	logic signed [UNWRAP_BITS-1:0] delta;
	logic signed [31:0]     off;
	logic [UNWRAP_BITS-1:0] dlt;
	logic signed [NB-1:0]   d_now;
	logic signed [NB-1:0]   err_now, n_div, mag_now, n_snap;
	logic                   snap_hit;
	logic signed [WIDE-1:0] q_signed;
	logic                   lo_stop, hi_stop;

	hdt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (width_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);

	// A delta of exactly half a turn stays positive.
	assign diff  = raw_q - last_raw_q;
	assign delta = (diff > {1'b1, {(ANGLE_BITS-1){1'b0}}}) ?
		UNWRAP_BITS'($signed({1'b1, diff})) : UNWRAP_BITS'($signed({1'b0, diff}));
	assign off   = anchor_pos_q * $signed({1'b0, width_q});
	assign dlt   = unwrapped_q - anchor_q;
	assign d_now = NB'($signed(dlt));

	assign q_signed = neg_q ? -$signed(WIDE'(div_quo)) : $signed(WIDE'(div_quo));
	assign n_div    = clamp_idx(q_signed[NB-1:0], lower_q, upper_q);
	assign err_now  = d_q - prod_q[NB-1:0];
	assign mag_now  = err_now < 0 ? -err_now : err_now;
	assign snap_hit = {mag_now, 9'b0} > (NB+9)'(width_q) * (NB+9)'(snap_q);
	assign n_snap   = clamp_idx(err_now > 0 ? n_q + NB'(1) : n_q - NB'(1), lower_q, upper_q);
	assign lo_stop  = lower_q != NO_BOUND && n_q <= NB'(lower_q) && err_q < 0;
	assign hi_stop  = upper_q != NO_BOUND && n_q >= NB'(upper_q) && err_q > 0;

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		div_num   = '0;
		case (state_q)
			S_IDLE: if (in_valid) state_d = S_UNW;
			S_UNW:  state_d = S_ANC;
			S_ANC:  state_d = S_DIFF;
			S_DIFF: begin
				if (width_q == '0) begin
					state_d = S_OUT;
				end else begin
					div_start = 1'b1;
					div_num   = NUM_W'(unsigned'(d_now < 0 ? -d_now : d_now));
					state_d   = S_DIV1;
				end
			end
			S_DIV1: if (div_done) state_d = S_MUL;
			S_MUL:  state_d = S_ERR;
			S_ERR:  state_d = (!snapped_q && snap_hit) ? S_MUL : S_GAIN;
			S_GAIN: state_d = S_TORQ;
			S_TORQ: begin
				div_start = 1'b1;
				div_num   = {unsigned'(err_q < 0 ? -err_q : err_q), {FRACTION_BITS{1'b0}}};
				state_d   = S_DIV2;
			end
			S_DIV2: if (div_done) state_d = S_OUT;
			S_OUT:  if (!out_valid || out_ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			out_valid    <= 1'b0;
			width_q      <= 15'd1024;
			lower_q      <= NO_BOUND;
			upper_q      <= NO_BOUND;
			snap_q       <= 10'd256;
			dgain_q      <= '0;
			egain_q      <= '0;
			anchor_pos_q <= '0;
			seeded_q     <= 1'b0;
			last_raw_q   <= '0;
			unwrapped_q  <= '0;
			anchor_q     <= '0;
			held_pos_q   <= '0;
			held_frac_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_OUT && (!out_valid || out_ready)) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			if (cfg_valid) begin
				case (cfg_index)
					REG_WIDTH:  width_q      <= cfg_data[14:0];
					REG_LOWER:  lower_q      <= cfg_data;
					REG_UPPER:  upper_q      <= cfg_data;
					REG_SNAP:   snap_q       <= cfg_data[9:0];
					REG_DGAIN:  dgain_q      <= cfg_data;
					REG_EGAIN:  egain_q      <= cfg_data;
					REG_ANCHOR: anchor_pos_q <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid && !seeded_q) begin
						seeded_q    <= 1'b1;
						last_raw_q  <= encoder_angle;
						unwrapped_q <= UNWRAP_BITS'(encoder_angle);
						anchor_q    <= UNWRAP_BITS'(encoder_angle);
					end
				end
				S_UNW: begin
					unwrapped_q <= unwrapped_q + delta;
					last_raw_q  <= raw_q;
				end
				S_ANC: if (reanchor_q) anchor_q <= unwrapped_q - UNWRAP_BITS'(off);
				S_DIV2: begin
					if (div_done) begin
						held_pos_q  <= sat16(WIDE'(n_q));
						held_frac_q <= sat16(q_signed);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				raw_q      <= encoder_angle;
				reanchor_q <= reanchor;
				snapped_q  <= 1'b0;
				torque_q   <= '0;
			end
			S_DIFF: begin
				neg_q <= d_now < 0;
				d_q   <= d_now;
			end
			S_ANC: ;
			S_DIV1: if (div_done) n_q <= n_div;
			S_MUL:  prod_q <= PW'(n_q) * PW'($signed({2'b0, width_q}));
			S_ERR: begin
				if (!snapped_q && snap_hit) begin
					n_q       <= n_snap;
					snapped_q <= 1'b1;
				end else begin
					err_q <= err_now;
				end
			end
			S_GAIN: prod_q <= -(PW'(err_q) *
				PW'($signed({1'b0, (lo_stop || hi_stop) ? egain_q : dgain_q})));
			S_TORQ: begin
				torque_q <= sat16(WIDE'(prod_q));
				neg_q    <= err_q < 0;
			end
			default: ;
		endcase
		if (state_q == S_OUT && (!out_valid || out_ready)) begin
			torque       <= torque_q;
			position     <= held_pos_q;
			sub_position <= held_frac_q;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/hdt_div.sv -----
// Shared restoring divider: q = (2m + w) / (2w), one quotient bit per cycle.
// Depends on hdt_pkg for the operand widths.
`default_nettype none
module hdt_div (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [hdt_pkg::NUM_W-1:0] num,
	input  wire logic [14:0]              den,
	output logic                          done,
	output logic [hdt_pkg::DIVN_W-1:0]    quo
);
	import hdt_pkg::*;

	logic [DIVN_W-1:0] dq_q;
	logic [16:0]       rem_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic [16:0]       trial;
	logic [16:0]       den2;
	logic              fits;

	assign den2  = {1'b0, den, 1'b0};
	assign trial = {rem_q[15:0], dq_q[DIVN_W-1]};
	assign fits  = trial >= den2;
	assign quo   = dq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIVN_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= {num, 1'b0} + DIVN_W'(den);
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? trial - den2 : trial;
			dq_q  <= {dq_q[DIVN_W-2:0], fits};
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/hdt_check.sv -----
// Port-level checker for the haptic detent torque block, with its bind statement.
// Does not import hdt_pkg; it depends on the haptic_detent_torque ports that it binds to.
`default_nettype none
module hdt_check (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [15:0] torque,
	input wire logic cfg_ready
);

	// A result waiting to be taken holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(torque))
		else $error("result dropped or changed while stalled");

	// The sequencer stays busy, and so not ready, after taking a request.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready ##1 !in_ready)
		else $error("request taken while still busy");

	// A new result is produced only at the end of a busy period.
	a_rose: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared while idle");

	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");

endmodule

bind haptic_detent_torque hdt_check u_hdt_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.torque    (torque),
	.cfg_ready (cfg_ready)
);
`default_nettype wire
